// ===== src/u8cp_pkg.sv =====
// shared constants and result type for the utf-8 code point decoder
`timescale 1ns / 1ps

package u8cp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LEFT_W  = 2;
  localparam int unsigned CONT_W  = 6;

  // sequence lengths
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // lead byte classification bits
  localparam int unsigned BIT_MULTI = 7;
  localparam int unsigned BIT_LEN3  = 5;
  localparam int unsigned BIT_LEN4  = 4;
  localparam int unsigned BIT_BAD   = 3;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_bytes;
    logic             bad_lead;
    logic             string_end;
    logic [CNT_W-1:0] char_count;
  } u8cp_result_t;

endpackage

// ===== src/utf8_to_code_point_decoder.sv =====
// utf-8 byte stream to code point decoder, one byte per beat
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_byte
//  out     | output    | out_valid / out_stall | out_code_point, out_seq_bytes,
//          |           |                       | out_bad_lead, out_string_end,
//          |           |                       | out_char_count
//
// one byte per cycle sustained while the output is not stalled; a byte is held
// in the input register and its result, if any, enters the output register as
// the byte leaves it; the decode state (phase, pending bytes, partial code point,
// count) also updates as the byte leaves, so a following byte sees it at once
// synchronous active-low reset returns to lead position with a zero count
// a stalled output only holds back bytes that would produce a result

module utf8_to_code_point_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u8cp_pkg::BYTE_W-1:0]   in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8cp_pkg::CP_W-1:0]     out_code_point,
  output logic [u8cp_pkg::LEN_W-1:0]    out_seq_bytes,
  output logic                          out_bad_lead,
  output logic                          out_string_end,
  output logic [u8cp_pkg::CNT_W-1:0]    out_char_count
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_CONT,
    PH_SKIP
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [u8cp_pkg::LEFT_W-1:0]    bytes_left_r, bytes_left_nxt;
  logic [u8cp_pkg::CP_W-1:0]      partial_r, partial_nxt;
  logic [u8cp_pkg::LEN_W-1:0]     seq_total_r, seq_total_nxt;
  logic [u8cp_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [u8cp_pkg::CNT_W-1:0]     count_inc;
  logic [u8cp_pkg::CP_W-1:0]      shifted;

  logic [u8cp_pkg::BYTE_W-1:0]    byte_r;
  logic                           byte_valid_r;

  u8cp_pkg::u8cp_result_t         res;
  logic                           res_valid;
  u8cp_pkg::u8cp_result_t         out_r;
  logic                           out_valid_r;

  logic                           out_free;
  logic                           proc_fire;
  logic                           in_accept;

  assign count_inc = (&count_r) ? count_r : count_r + 1'b1;
  assign shifted   = {partial_r[u8cp_pkg::CP_W-u8cp_pkg::CONT_W-1:0],
                      byte_r[u8cp_pkg::CONT_W-1:0]};

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    partial_nxt    = partial_r;
    seq_total_nxt  = seq_total_r;
    count_nxt      = count_r;
    res_valid      = 1'b0;
    res            = '0;
    unique case (phase_r)
      PH_SKIP: begin
        if (byte_r == '0) begin
          phase_nxt = PH_LEAD;
          count_nxt = '0;
        end
      end
      PH_CONT: begin
        partial_nxt    = shifted;
        bytes_left_nxt = bytes_left_r - 1'b1;
        if (bytes_left_r == 2'd1) begin
          phase_nxt     = PH_LEAD;
          count_nxt     = count_inc;
          res_valid     = 1'b1;
          res.code_point = shifted;
          res.seq_bytes  = seq_total_r;
        end
      end
      default: begin
        priority if (byte_r == '0) begin
          res_valid      = 1'b1;
          res.string_end = 1'b1;
          res.char_count = count_r;
          count_nxt      = '0;
          phase_nxt      = PH_LEAD;
        end else if (!byte_r[u8cp_pkg::BIT_MULTI]) begin
          res_valid      = 1'b1;
          res.code_point = u8cp_pkg::CP_W'(byte_r);
          res.seq_bytes  = u8cp_pkg::LEN_ONE;
          count_nxt      = count_inc;
        end else if (!byte_r[u8cp_pkg::BIT_LEN3]) begin
          partial_nxt    = u8cp_pkg::CP_W'(byte_r[4:0]);
          seq_total_nxt  = u8cp_pkg::LEN_TWO;
          bytes_left_nxt = 2'd1;
          phase_nxt      = PH_CONT;
        end else if (!byte_r[u8cp_pkg::BIT_LEN4]) begin
          partial_nxt    = u8cp_pkg::CP_W'(byte_r[3:0]);
          seq_total_nxt  = u8cp_pkg::LEN_THREE;
          bytes_left_nxt = 2'd2;
          phase_nxt      = PH_CONT;
        end else if (!byte_r[u8cp_pkg::BIT_BAD]) begin
          partial_nxt    = u8cp_pkg::CP_W'(byte_r[2:0]);
          seq_total_nxt  = u8cp_pkg::LEN_FOUR;
          bytes_left_nxt = 2'd3;
          phase_nxt      = PH_CONT;
        end else begin
          res_valid      = 1'b1;
          res.bad_lead   = 1'b1;
          bytes_left_nxt = '0;
          phase_nxt      = PH_SKIP;
        end
      end
    endcase
  end

  // bytes with no result never wait for the output side
  assign out_free  = !out_valid_r || !out_stall;
  assign proc_fire = byte_valid_r && (!res_valid || out_free);
  assign in_stall  = byte_valid_r && !proc_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      bytes_left_r <= '0;
      partial_r    <= '0;
      seq_total_r  <= '0;
      count_r      <= '0;
      byte_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (proc_fire) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        partial_r    <= partial_nxt;
        seq_total_r  <= seq_total_nxt;
        count_r      <= count_nxt;
      end
      if (in_accept) begin
        byte_valid_r <= 1'b1;
        byte_r       <= in_byte;
      end else if (proc_fire) begin
        byte_valid_r <= 1'b0;
      end
      if (proc_fire && res_valid) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_r.code_point;
  assign out_seq_bytes  = out_r.seq_bytes;
  assign out_bad_lead   = out_r.bad_lead;
  assign out_string_end = out_r.string_end;
  assign out_char_count = out_r.char_count;

  // a sequence in progress always has bytes pending
  a_cont_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CONT |-> bytes_left_r != '0)
    else $error("continuation phase with no pending bytes");

  // a bad lead beat sends the decoder into discard
  a_bad_skip: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && res_valid && res.bad_lead |=> phase_r == PH_SKIP)
    else $error("bad lead did not enter discard");

  // each result beat is exactly one kind
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_r.bad_lead, out_r.string_end,
                             out_r.seq_bytes != u8cp_pkg::LEN_NONE}))
    else $error("result beat is not exactly one kind");

  // a result is never dropped by a new one while the output is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(proc_fire && res_valid))
    else $error("stalled result overwritten");

  // end of string clears the count
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && res_valid && res.string_end |=> count_r == '0)
    else $error("count not cleared at end of string");

endmodule

// ===== bench/u8cp_checker.sv =====
// checker for the utf-8 decoder: predicts results from accepted bytes and compares them
`timescale 1ns / 1ps

module u8cp_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [u8cp_pkg::BYTE_W-1:0] in_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [u8cp_pkg::CP_W-1:0]   out_code_point,
  input  logic [u8cp_pkg::LEN_W-1:0]  out_seq_bytes,
  input  logic                        out_bad_lead,
  input  logic                        out_string_end,
  input  logic [u8cp_pkg::CNT_W-1:0]  out_char_count,
  output int                          mismatches,
  output int                          pending,
  output int                          checked,
  output int                          ends_seen,
  output int                          bad_seen
);

  typedef enum logic [1:0] {
    SEEK_LEAD,
    IN_SEQ,
    SKIP_TO_NUL
  } scan_t;

  scan_t                       scan;
  logic [u8cp_pkg::LEFT_W-1:0] conts_left;
  logic [u8cp_pkg::CP_W-1:0]   acc_point;
  logic [u8cp_pkg::LEN_W-1:0]  seq_len;
  logic [u8cp_pkg::CNT_W-1:0]  str_points;

  u8cp_pkg::u8cp_result_t expected_points [$];

  task automatic count_point();
    if (str_points != '1) str_points = str_points + 1'b1;
  endtask

  task automatic decode_byte(input logic [u8cp_pkg::BYTE_W-1:0] b);
    u8cp_pkg::u8cp_result_t r;
    r = '0;
    case (scan)
      SKIP_TO_NUL: begin
        // discarded bytes give nothing, the closing zero included
        if (b == '0) begin
          scan = SEEK_LEAD;
          str_points = '0;
        end
      end
      IN_SEQ: begin
        // continuation bits merged without any check of the top two bits
        acc_point = {acc_point[u8cp_pkg::CP_W-u8cp_pkg::CONT_W-1:0],
                     b[u8cp_pkg::CONT_W-1:0]};
        conts_left = conts_left - 1'b1;
        if (conts_left == '0) begin
          scan = SEEK_LEAD;
          count_point();
          r.code_point = acc_point;
          r.seq_bytes = seq_len;
          expected_points.push_back(r);
        end
      end
      default: begin
        if (b == '0) begin
          r.string_end = 1'b1;
          r.char_count = str_points;
          str_points = '0;
          expected_points.push_back(r);
        end else if (!b[u8cp_pkg::BIT_MULTI]) begin
          count_point();
          r.code_point = u8cp_pkg::CP_W'(b);
          r.seq_bytes = u8cp_pkg::LEN_ONE;
          expected_points.push_back(r);
        end else if (b[u8cp_pkg::BIT_LEN3] && b[u8cp_pkg::BIT_LEN4] &&
                     b[u8cp_pkg::BIT_BAD]) begin
          scan = SKIP_TO_NUL;
          conts_left = '0;
          r.bad_lead = 1'b1;
          expected_points.push_back(r);
        end else begin
          if (!b[u8cp_pkg::BIT_LEN3]) begin
            acc_point = u8cp_pkg::CP_W'(b[4:0]);
            seq_len = u8cp_pkg::LEN_TWO;
          end else if (!b[u8cp_pkg::BIT_LEN4]) begin
            acc_point = u8cp_pkg::CP_W'(b[3:0]);
            seq_len = u8cp_pkg::LEN_THREE;
          end else begin
            acc_point = u8cp_pkg::CP_W'(b[2:0]);
            seq_len = u8cp_pkg::LEN_FOUR;
          end
          conts_left = u8cp_pkg::LEFT_W'(seq_len - 1'b1);
          scan = IN_SEQ;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  task automatic check_result();
    u8cp_pkg::u8cp_result_t want;
    if (expected_points.size() == 0) begin
      $error("unexpected beat: code_point %0h seq_bytes %0d bad_lead %0b string_end %0b",
             out_code_point, out_seq_bytes, out_bad_lead, out_string_end);
      mismatches = mismatches + 1;
    end else begin
      want = expected_points.pop_front();
      check_field("code_point", want.code_point, out_code_point);
      check_field("seq_bytes", want.seq_bytes, out_seq_bytes);
      check_field("bad_lead", want.bad_lead, out_bad_lead);
      check_field("string_end", want.string_end, out_string_end);
      check_field("char_count", want.char_count, out_char_count);
      checked = checked + 1;
      if (want.string_end) ends_seen = ends_seen + 1;
      if (want.bad_lead) bad_seen = bad_seen + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan = SEEK_LEAD;
      conts_left = '0;
      acc_point = '0;
      seq_len = u8cp_pkg::LEN_NONE;
      str_points = '0;
      expected_points.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte);
      if (out_valid && !out_stall) check_result();
    end
    pending <= expected_points.size();
  end

endmodule

// ===== bench/tb_utf8_to_code_point_decoder.sv =====
// testbench top for the utf-8 decoder: byte stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_utf8_to_code_point_decoder;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 640;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIRECTED   = 26;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic [u8cp_pkg::BYTE_W-1:0] in_byte = '0;
  logic                        out_stall = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic [u8cp_pkg::CP_W-1:0]   out_code_point;
  logic [u8cp_pkg::LEN_W-1:0]  out_seq_bytes;
  logic                        out_bad_lead;
  logic                        out_string_end;
  logic [u8cp_pkg::CNT_W-1:0]  out_char_count;

  int mismatches;
  int pending;
  int checked;
  int ends_seen;
  int bad_seen;
  int cycles = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // end of empty string, ascii extremes, 2/3/4-byte leads at their limits,
  // a zero taken as continuation, bad leads with discarded bytes
  logic [u8cp_pkg::BYTE_W-1:0] directed_bytes [N_DIRECTED] = '{
    8'h00, 8'h41, 8'h7F, 8'hC2, 8'h80, 8'h80, 8'h00, 8'hEF, 8'hBF, 8'hBF,
    8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF0, 8'h80, 8'h80, 8'h80, 8'h00, 8'hFF,
    8'h41, 8'hC2, 8'h00, 8'hF8, 8'h00, 8'h00
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf8_to_code_point_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_seq_bytes  (out_seq_bytes),
    .out_bad_lead   (out_bad_lead),
    .out_string_end (out_string_end),
    .out_char_count (out_char_count)
  );

  u8cp_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_seq_bytes  (out_seq_bytes),
    .out_bad_lead   (out_bad_lead),
    .out_string_end (out_string_end),
    .out_char_count (out_char_count),
    .mismatches     (mismatches),
    .pending        (pending),
    .checked        (checked),
    .ends_seen      (ends_seen),
    .bad_seen       (bad_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : rx_pattern
    rx_mode_t mode;
    int span;
    int k;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      for (k = 0; k < span && !(hold_req && !hold_done); k++) begin
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 1) == 1);
          default:     out_stall <= ((k % 7) < 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // LEN_NONE asks for a bad lead
  function automatic logic [u8cp_pkg::BYTE_W-1:0] lead_byte(
    input logic [u8cp_pkg::LEN_W-1:0] len);
    logic [u8cp_pkg::BYTE_W-1:0] r;
    r = u8cp_pkg::BYTE_W'($urandom);
    r[u8cp_pkg::BIT_MULTI] = (len != u8cp_pkg::LEN_ONE);
    case (len)
      u8cp_pkg::LEN_ONE: begin
        if (r == '0) r = 8'h20;
      end
      u8cp_pkg::LEN_TWO: r[u8cp_pkg::BIT_LEN3] = 1'b0;
      u8cp_pkg::LEN_THREE:
        {r[u8cp_pkg::BIT_LEN3], r[u8cp_pkg::BIT_LEN4]} = 2'b10;
      u8cp_pkg::LEN_FOUR:
        {r[u8cp_pkg::BIT_LEN3], r[u8cp_pkg::BIT_LEN4], r[u8cp_pkg::BIT_BAD]} = 3'b110;
      default:
        {r[u8cp_pkg::BIT_LEN3], r[u8cp_pkg::BIT_LEN4], r[u8cp_pkg::BIT_BAD]} = 3'b111;
    endcase
    return r;
  endfunction

  function automatic logic [u8cp_pkg::BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 99) < 85) return {2'b10, 6'($urandom)};
    return u8cp_pkg::BYTE_W'($urandom);
  endfunction

  task automatic offer_byte(input logic [u8cp_pkg::BYTE_W-1:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
  endtask

  task automatic send_string();
    int kind;
    logic [u8cp_pkg::LEN_W-1:0] len;
    repeat ($urandom_range(0, 10)) begin
      kind = $urandom_range(0, 99);
      len = u8cp_pkg::LEN_TWO + u8cp_pkg::LEN_W'($urandom_range(0, 2));
      if (kind < 40) begin
        offer_byte(lead_byte(u8cp_pkg::LEN_ONE));
      end else if (kind < 85) begin
        offer_byte(lead_byte(len));
        repeat (len - 1) offer_byte(cont_byte());
      end else if (kind < 93) begin
        // continuations of any value, zero and lead-like bytes included
        offer_byte(lead_byte(len));
        repeat (len - 1) offer_byte(u8cp_pkg::BYTE_W'($urandom));
      end else begin
        offer_byte(lead_byte(u8cp_pkg::LEN_NONE));
        repeat ($urandom_range(0, 4))
          offer_byte(u8cp_pkg::BYTE_W'($urandom_range(1, 255)));
        offer_byte(8'h00);
      end
    end
    offer_byte(8'h00);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12))
      offer_byte(($urandom_range(0, 9) == 0) ? 8'h00 : u8cp_pkg::BYTE_W'($urandom));
    // enough zeros to land back in lead position from any state
    repeat (4) offer_byte(8'h00);
  endtask

  initial begin : stimulus
    int base;
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) offer_byte(directed_bytes[i]);

    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      if (!hold_req && bytes_sent - base > RANDOM_BYTES / 2) begin
        // keep offering while the receiver holds off so the block backs up
        hold_req = 1'b1;
        gaps_on = 1'b0;
        repeat (60) offer_byte(lead_byte(u8cp_pkg::LEN_ONE));
        gaps_on = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_string();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d results checked: %0d string ends, %0d bad leads",
             bytes_sent, checked, ends_seen, bad_seen);
    $display("mixed 1 to 4 byte strings, loose continuations, noise and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
